### design/assert_macros.svh
// Assertion macros shared by the design files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define LPSB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lpsb assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define LPSB_ASSERT_IMP(lbl, clk, rst_n, cond, cons) \
    `LPSB_ASSERT(lbl, clk, rst_n, (cond) |-> (cons))

`endif

### design/lpsb_pkg.sv
// Constants, types and arithmetic limits of the lidar packet parser.
// No dependencies.
package lpsb_pkg;

    localparam int BINS              = 400;
    localparam int POINTS_PER_PACKET = 8;
    localparam int PAYLOAD_BYTES     = 32;

    localparam int BIN_W   = 9;
    localparam int RAM_AW  = $clog2(PAYLOAD_BYTES);
    localparam int CNT_W   = $clog2(PAYLOAD_BYTES);
    localparam int POS_W   = 7;
    localparam int PI_W    = $clog2(POINTS_PER_PACKET + 1);
    localparam int PT_SH   = $clog2(POINTS_PER_PACKET);
    localparam int PBASE   = 4;
    localparam int EPOS    = PBASE + 3 * POINTS_PER_PACKET;

    localparam int ANGLE_BIAS64 = 40960;
    localparam int FULL_TURN64  = 23040;
    localparam int HALF_TURN64  = 11520;
    localparam int FULL_TURN512 = 184320;
    localparam int HALF512      = FULL_TURN512 / 2;
    localparam int AVG_WEIGHT   = 655;
    localparam int AVG_KEEP     = 65536 - AVG_WEIGHT;

    localparam int ANG_W  = 23;
    localparam int ACC_W  = 26;
    localparam int BMUL_W = $clog2(BINS + 1);
    localparam int N_W    = ANG_W + BMUL_W;
    localparam int FT_SH  = 12;
    localparam int FT_ODD = FULL_TURN512 / (2 ** FT_SH);
    localparam int K1     = 27;
    localparam int M1     = (2 ** K1 + FT_ODD - 1) / FT_ODD;
    localparam int M1_W   = $clog2(M1 + 1);
    localparam int P1_W   = N_W - FT_SH + M1_W;
    localparam int Q_W    = P1_W - K1;
    localparam int BIAS   = BINS * ((2 ** (ANG_W - 1)) / FULL_TURN512 + 1);
    localparam int U_W    = 16;
    localparam int K2     = 28;
    localparam int M2     = (2 ** K2 + BINS - 1) / BINS;
    localparam int M2_W   = $clog2(M2 + 1);
    localparam int P2_W   = U_W + M2_W;

    typedef struct packed {
        logic                    go;
        logic signed [ANG_W-1:0] ang;
    } t_pt_req;

    typedef struct packed {
        logic             done;
        logic [BIN_W-1:0] bin;
    } t_pt_rsp;

endpackage

### design/lpsb_if.sv
// Valid/ready channels for received bytes and for scan points.
// Depends on lpsb_pkg.
interface lpsb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpsb_out_if import lpsb_pkg::*;;
    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] bin_index;
    logic [15:0]      distance;
    logic [7:0]       quality;
    logic [23:0]      avg_speed;
    logic             scan_done;
    logic             last_in_packet;
    modport source (output valid, output bin_index, output distance, output quality,
                    output avg_speed, output scan_done, output last_in_packet,
                    input ready);
    modport sink (input valid, input bin_index, input distance, input quality,
                  input avg_speed, input scan_done, input last_in_packet,
                  output ready);
endinterface

### design/lpsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpsb_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/lpsb_point.sv
// Multi-cycle unit that turns a point angle in 1/512 degree into a mirrored scan bin.
// Depends on lpsb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lpsb_point import lpsb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_pt_req i_req,
    output t_pt_rsp o_rsp
);
    logic [2:0]       r_stg, n_stg;
    logic             r_neg, n_neg;
    logic [ANG_W-1:0] r_mag, n_mag;
    logic [N_W-1:0]   r_n, n_n;
    logic [P1_W-1:0]  r_p1, n_p1;
    logic [U_W-1:0]   r_u, n_u;
    logic [P2_W-1:0]  r_p2, n_p2;
    logic             r_done, n_done;
    logic [BIN_W-1:0] r_bin, n_bin;
    logic [Q_W-1:0]   q;
    logic [U_W-1:0]   q2, w;

    always_comb begin
        n_stg  = r_stg;
        n_neg  = r_neg;
        n_mag  = r_mag;
        n_n    = r_n;
        n_p1   = r_p1;
        n_u    = r_u;
        n_p2   = r_p2;
        n_done = 1'b0;
        n_bin  = r_bin;
        q      = r_p1[P1_W-1:K1];
        q2     = U_W'(r_p2[P2_W-1:K2]);
        w      = r_u - U_W'(q2 * U_W'(BINS));
        case (r_stg)
            3'd0: begin
                if (i_req.go) begin
                    n_neg = i_req.ang[ANG_W-1];
                    n_mag = i_req.ang[ANG_W-1] ? ANG_W'(-i_req.ang) : ANG_W'(i_req.ang);
                    n_stg = 3'd1;
                end
            end
            3'd1: begin
                n_n   = N_W'(r_mag) * N_W'(BINS) + N_W'(HALF512);
                n_stg = 3'd2;
            end
            3'd2: begin
                n_p1  = P1_W'(r_n[N_W-1:FT_SH]) * P1_W'(M1);
                n_stg = 3'd3;
            end
            3'd3: begin
                n_u   = r_neg ? U_W'(BIAS) - U_W'(q) : U_W'(BIAS) + U_W'(q);
                n_stg = 3'd4;
            end
            3'd4: begin
                n_p2  = P2_W'(r_u) * P2_W'(M2);
                n_stg = 3'd5;
            end
            3'd5: begin
                n_bin  = BIN_W'(U_W'(BINS - 1) - w);
                n_done = 1'b1;
                n_stg  = 3'd0;
            end
            default: begin
                n_stg = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_stg  <= n_stg;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_n   <= n_n;
        r_p1  <= n_p1;
        r_u   <= n_u;
        r_p2  <= n_p2;
        r_bin <= n_bin;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.bin  = r_bin;

    `LPSB_ASSERT_IMP(a_go_idle, i_clk, i_rst_n, i_req.go, r_stg == 3'd0)
    `LPSB_ASSERT_IMP(a_bin_range, i_clk, i_rst_n, o_rsp.done, o_rsp.bin < BIN_W'(BINS))
    `LPSB_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_rsp.done, r_stg == 3'd0)
endmodule

### design/lidar_packet_to_scan_bins.sv
// Top level of the rotating lidar packet parser: sync hunt, payload RAM, point sequencer.
// Depends on lpsb_pkg, lpsb_if, lpsb_ram, lpsb_point and assert_macros.svh.
//
//  channel  | dir | words
//  ---------+-----+------------------------------------------
//  in_ch    | in  | one received byte per word
//  out_ch   | out | one scan point per word, eight per packet
//  apb      | in  | sync_word at 0x0, angle_offset at 0x4
//
// Sync and payload bytes are taken one per cycle.
// After the last payload byte the input stalls until the packet is done: the header is read,
// the average is updated, then per point its three bytes are read through the single RAM read
// port, the bin unit computes its bin and the point is put in the output register.
// The output register stalls the point sequencer while a point waits to be taken.
// Reset is synchronous and active low; the payload RAM is not cleared.
`include "assert_macros.svh"
module lidar_packet_to_scan_bins import lpsb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpsb_in_if.sink     in_ch,
    lpsb_out_if.source  out_ch,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_COLL = 3'd1;
    localparam logic [2:0] ST_HDR  = 3'd2;
    localparam logic [2:0] ST_AVG1 = 3'd3;
    localparam logic [2:0] ST_AVG2 = 3'd4;
    localparam logic [2:0] ST_PT   = 3'd5;
    localparam logic [2:0] ST_CALC = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [31:0]             r_sync_word;
    logic signed [15:0]      r_angle_offset;
    logic [2:0]              r_state, n_state;
    logic [1:0]              r_phase, n_phase;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [2:0]              r_k, n_k;
    logic [PI_W-1:0]         r_i, n_i;
    logic [7:0]              r_hdr [6];
    logic [7:0]              n_hdr [6];
    logic [7:0]              r_pb [3];
    logic [7:0]              n_pb [3];
    logic                    r_rd_ok, n_rd_ok;
    logic [39:0]             r_p, n_p;
    logic [23:0]             r_avg, n_avg;
    logic                    r_avg_ok, n_avg_ok;
    logic signed [16:0]      r_prev, n_prev;
    logic signed [16:0]      r_start, n_start;
    logic signed [20:0]      r_base, n_base;
    logic signed [ACC_W-1:0] r_d8, n_d8;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic                    r_done, n_done;
    logic [BIN_W-1:0]        r_bin, n_bin;
    logic                    r_ovalid, n_ovalid;
    logic [BIN_W-1:0]        r_obin, n_obin;
    logic [15:0]             r_odist, n_odist;
    logic [7:0]              r_oqual, n_oqual;
    logic [23:0]             r_oavg, n_oavg;
    logic                    r_odone, n_odone;
    logic                    r_olast, n_olast;

    logic               in_acc;
    logic               cfg_wr;
    logic [POS_W-1:0]   rd_pos;
    logic [7:0]         ram_rdata;
    logic [7:0]         rd_byte;
    logic [7:0]         want;
    logic [23:0]        x;
    logic [39:0]        sum;
    logic signed [17:0] s18, e18;
    logic signed [18:0] diff;
    logic signed [20:0] bsum;
    logic               last_pt;
    t_pt_req            pt_req;
    t_pt_rsp            pt_rsp;

    assign o_pready    = 1'b1;
    assign cfg_wr      = i_psel && i_penable && i_pwrite;
    assign o_prdata    = i_paddr[2] ? {{16{r_angle_offset[15]}}, r_angle_offset} : r_sync_word;
    assign in_ch.ready = (r_state == ST_HUNT) || (r_state == ST_COLL);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign rd_byte     = r_rd_ok ? ram_rdata : 8'h00;
    assign want        = 8'(r_sync_word >> {r_phase, 3'b000});
    assign x           = {r_hdr[1], r_hdr[0], 8'h00};
    assign last_pt     = r_i == PI_W'(POINTS_PER_PACKET - 1);
    assign s18         = $signed({2'b00, r_hdr[3], r_hdr[2]}) - 18'sd40960;
    assign e18         = $signed({2'b00, r_hdr[5], r_hdr[4]}) - 18'sd40960;
    assign diff        = (e18 > s18) ? 19'(e18) - 19'(s18)
                                     : 19'(e18) - 19'(s18) + 19'sd23040;
    assign bsum        = 21'(s18) + 21'(r_angle_offset) + 21'sd11520;
    assign sum         = r_p + 40'(x) * 40'(AVG_WEIGHT) + 40'd32768;

    assign pt_req.go  = (r_state == ST_PT) && (r_k == 3'd3);
    assign pt_req.ang = ANG_W'(r_base) + ANG_W'(r_acc >>> PT_SH);

    always_comb begin
        rd_pos = '0;
        case (r_state)
            ST_HDR: begin
                case (r_k)
                    3'd4:    rd_pos = POS_W'(EPOS);
                    3'd5:    rd_pos = POS_W'(EPOS + 1);
                    default: rd_pos = POS_W'(r_k);
                endcase
            end
            ST_PT: begin
                rd_pos = POS_W'(PBASE) + POS_W'(r_i) * POS_W'(3) + POS_W'(r_k);
            end
            default: begin
                rd_pos = '0;
            end
        endcase
    end

    lpsb_ram #(.W(8), .D(PAYLOAD_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (r_state == ST_COLL)),
        .i_waddr (RAM_AW'(r_cnt)),
        .i_wdata (in_ch.rx_byte),
        .i_raddr (rd_pos[RAM_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    lpsb_point u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (pt_req),
        .o_rsp   (pt_rsp)
    );

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_i      = r_i;
        n_hdr    = r_hdr;
        n_pb     = r_pb;
        n_rd_ok  = rd_pos < POS_W'(PAYLOAD_BYTES);
        n_p      = r_p;
        n_avg    = r_avg;
        n_avg_ok = r_avg_ok;
        n_prev   = r_prev;
        n_start  = r_start;
        n_base   = r_base;
        n_d8     = r_d8;
        n_acc    = r_acc;
        n_done   = r_done;
        n_bin    = r_bin;
        n_ovalid = r_ovalid && !out_ch.ready;
        n_obin   = r_obin;
        n_odist  = r_odist;
        n_oqual  = r_oqual;
        n_oavg   = r_oavg;
        n_odone  = r_odone;
        n_olast  = r_olast;
        case (r_state)
            ST_HUNT: begin
                if (in_acc) begin
                    if (in_ch.rx_byte == want) begin
                        if (r_phase == 2'd3) begin
                            n_phase = 2'd0;
                            n_cnt   = '0;
                            n_state = ST_COLL;
                        end else begin
                            n_phase = r_phase + 2'd1;
                        end
                    end else begin
                        n_phase = 2'd0;
                    end
                end
            end
            ST_COLL: begin
                if (in_acc) begin
                    if (r_cnt == CNT_W'(PAYLOAD_BYTES - 1)) begin
                        n_cnt   = '0;
                        n_k     = 3'd0;
                        n_state = ST_HDR;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            ST_HDR: begin
                if (r_k != 3'd0) begin
                    n_hdr[r_k - 3'd1] = rd_byte;
                end
                if (r_k == 3'd6) begin
                    n_state = ST_AVG1;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_AVG1: begin
                n_p      = 40'(r_avg_ok ? r_avg : x) * 40'(AVG_KEEP);
                n_avg_ok = 1'b1;
                n_state  = ST_AVG2;
            end
            ST_AVG2: begin
                n_avg   = sum[39:16];
                n_start = 17'(s18);
                n_done  = r_prev > 17'(s18);
                n_base  = bsum <<< 3;
                n_d8    = ACC_W'(diff) <<< 3;
                n_acc   = '0;
                n_i     = '0;
                n_k     = 3'd0;
                n_state = ST_PT;
            end
            ST_PT: begin
                if (r_k != 3'd0) begin
                    n_pb[2'(r_k - 3'd1)] = rd_byte;
                end
                if (r_k == 3'd3) begin
                    n_state = ST_CALC;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_CALC: begin
                if (pt_rsp.done) begin
                    n_bin   = pt_rsp.bin;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || out_ch.ready) begin
                    n_ovalid = 1'b1;
                    n_obin   = r_bin;
                    n_odist  = (r_pb[2] == 8'h00) ? 16'h0000 : {r_pb[1], r_pb[0]};
                    n_oqual  = r_pb[2];
                    n_oavg   = r_avg;
                    n_odone  = r_done;
                    n_olast  = last_pt;
                    if (last_pt) begin
                        if (r_done) begin
                            n_avg    = '0;
                            n_avg_ok = 1'b0;
                            n_prev   = '0;
                        end else begin
                            n_prev = r_start;
                        end
                        n_phase = 2'd0;
                        n_state = ST_HUNT;
                    end else begin
                        n_i     = r_i + PI_W'(1);
                        n_acc   = r_acc + r_d8;
                        n_k     = 3'd0;
                        n_state = ST_PT;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word    <= 32'd134458709;
            r_angle_offset <= '0;
            r_state        <= ST_HUNT;
            r_phase        <= 2'd0;
            r_cnt          <= '0;
            r_k            <= 3'd0;
            r_i            <= '0;
            r_avg          <= '0;
            r_avg_ok       <= 1'b0;
            r_prev         <= '0;
            r_ovalid       <= 1'b0;
        end else begin
            if (cfg_wr && !i_paddr[2]) begin
                r_sync_word <= i_pwdata;
            end
            if (cfg_wr && i_paddr[2]) begin
                r_angle_offset <= $signed(i_pwdata[15:0]);
            end
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_k      <= n_k;
            r_i      <= n_i;
            r_avg    <= n_avg;
            r_avg_ok <= n_avg_ok;
            r_prev   <= n_prev;
            r_ovalid <= n_ovalid;
        end
        r_hdr   <= n_hdr;
        r_pb    <= n_pb;
        r_rd_ok <= n_rd_ok;
        r_p     <= n_p;
        r_start <= n_start;
        r_base  <= n_base;
        r_d8    <= n_d8;
        r_acc   <= n_acc;
        r_done  <= n_done;
        r_bin   <= n_bin;
        r_obin  <= n_obin;
        r_odist <= n_odist;
        r_oqual <= n_oqual;
        r_oavg  <= n_oavg;
        r_odone <= n_odone;
        r_olast <= n_olast;
    end

    assign out_ch.valid          = r_ovalid;
    assign out_ch.bin_index      = r_obin;
    assign out_ch.distance       = r_odist;
    assign out_ch.quality        = r_oqual;
    assign out_ch.avg_speed      = r_oavg;
    assign out_ch.scan_done      = r_odone;
    assign out_ch.last_in_packet = r_olast;

    `LPSB_ASSERT_IMP(a_rsp_in_calc, i_clk, i_rst_n, pt_rsp.done, r_state == ST_CALC)
    `LPSB_ASSERT_IMP(a_phase_hunt, i_clk, i_rst_n, r_state != ST_HUNT, r_phase == 2'd0)
    `LPSB_ASSERT_IMP(a_cnt_coll, i_clk, i_rst_n, r_state != ST_COLL, r_cnt == '0)
endmodule

### sim/lpsb_point_checker.sv
`timescale 1ns / 1ps
// Checker for the lidar packet parser: predicts scan points and compares them with the output.
// Depends on lpsb_pkg and lpsb_if; it watches the byte channel, the point channel and the APB writes.
module lpsb_point_checker import lpsb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpsb_in_if          in_mon,
    lpsb_out_if         out_mon,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        o_pready,
    output int          fail_count,
    output int          points_pending
);

    localparam logic [2:0] ADDR_SYNC   = 3'd0;
    localparam logic [2:0] ADDR_OFFSET = 3'd4;

    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [15:0]      distance;
        logic [7:0]       quality;
        logic [23:0]      avg_speed;
        logic             scan_done;
        logic             last_in_packet;
    } t_point;

    logic [31:0]       sync_cfg;
    logic signed [15:0] offset_cfg;
    int                hunt_phase;
    int                payload_cnt;
    logic [7:0]        payload [PAYLOAD_BYTES];
    logic [23:0]       speed_avg;
    logic              speed_avg_ok;
    longint            last_start;
    t_point            exp_points [$];

    assign points_pending = exp_points.size();

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint round_quot(longint a, longint b);
        if (a >= 0) return (a + b / 2) / b;
        return -((-a + b / 2) / b);
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b);
        longint speed_x, acc, start_ang, end_ang, span, base512, ang, idx, wrapped;
        logic   rev_end;
        t_point p;
        if (hunt_phase < 4) begin
            if (b == sync_cfg[8*hunt_phase +: 8]) begin
                hunt_phase++;
                payload_cnt = 0;
            end else begin
                hunt_phase = 0;
            end
            return;
        end
        payload[payload_cnt] = b;
        payload_cnt++;
        if (payload_cnt < PAYLOAD_BYTES) return;
        hunt_phase = 0;
        payload_cnt = 0;

        speed_x = longint'({payload[1], payload[0]}) << 8;
        if (!speed_avg_ok) begin
            speed_avg = speed_x[23:0];
            speed_avg_ok = 1'b1;
        end
        acc = longint'(speed_avg) * AVG_KEEP + speed_x * AVG_WEIGHT + 32768;
        speed_avg = acc[39:16];

        start_ang = longint'({payload[3], payload[2]}) - ANGLE_BIAS64;
        end_ang = longint'({payload[EPOS+1], payload[EPOS]}) - ANGLE_BIAS64;
        span = (end_ang > start_ang) ? end_ang - start_ang : end_ang - start_ang + FULL_TURN64;
        base512 = (start_ang + longint'(offset_cfg) + HALF_TURN64) * 8;
        rev_end = last_start > start_ang;

        for (int i = 0; i < POINTS_PER_PACKET; i++) begin
            ang = base512 + floor_quot(span * 8 * i, POINTS_PER_PACKET);
            idx = round_quot(ang * BINS, FULL_TURN512);
            wrapped = idx - floor_quot(idx, BINS) * BINS;
            p.bin_index = BIN_W'(BINS - 1 - wrapped);
            p.quality = payload[PBASE + 3*i + 2];
            p.distance = (p.quality == 8'd0) ? 16'd0
                                             : {payload[PBASE + 3*i + 1], payload[PBASE + 3*i]};
            p.avg_speed = speed_avg;
            p.scan_done = rev_end;
            p.last_in_packet = (i == POINTS_PER_PACKET - 1);
            exp_points.push_back(p);
        end

        if (rev_end) begin
            speed_avg = '0;
            speed_avg_ok = 1'b0;
            last_start = 0;
        end else begin
            last_start = start_ang;
        end
    endtask

    always @(posedge i_clk) begin
        t_point got, want;
        if (!i_rst_n) begin
            sync_cfg = 32'd134458709;
            offset_cfg = '0;
            hunt_phase = 0;
            payload_cnt = 0;
            speed_avg = '0;
            speed_avg_ok = 1'b0;
            last_start = 0;
            fail_count = 0;
            exp_points.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && o_pready) begin
                if (i_paddr == ADDR_SYNC) sync_cfg = i_pwdata;
                else if (i_paddr == ADDR_OFFSET) offset_cfg = i_pwdata[15:0];
            end
            if (in_mon.valid && in_mon.ready) parse_rx_byte(in_mon.rx_byte);
            if (out_mon.valid && out_mon.ready) begin
                got = '{out_mon.bin_index, out_mon.distance, out_mon.quality,
                        out_mon.avg_speed, out_mon.scan_done, out_mon.last_in_packet};
                if (exp_points.size() == 0) begin
                    $display("%0t: unexpected point word, actual %p", $time, got);
                    fail_count++;
                end else begin
                    want = exp_points.pop_front();
                    if (got !== want) begin
                        $display("%0t: point mismatch, expected %p, actual %p",
                                 $time, want, got);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the lidar packet parser testbench: clock, reset, byte stimulus, output stalls, APB writes and verdict.
// Depends on lpsb_pkg, lpsb_if, lidar_packet_to_scan_bins and lpsb_point_checker.
module tb_top import lpsb_pkg::*;;

    localparam logic [2:0] ADDR_SYNC   = 3'd0;
    localparam logic [2:0] ADDR_OFFSET = 3'd4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;
    int          fail_count;
    int          points_pending;
    logic [31:0] sync_now;
    logic [7:0]  payload [PAYLOAD_BYTES];
    logic        no_idle;
    int          stall_left;
    int          start_raw;

    lpsb_in_if  in_ch ();
    lpsb_out_if out_ch ();

    lidar_packet_to_scan_bins i_dut (
        .i_clk, .i_rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .i_psel, .i_penable, .i_pwrite, .i_paddr, .i_pwdata, .o_prdata, .o_pready
    );

    lpsb_point_checker i_checker (
        .i_clk, .i_rst_n, .in_mon(in_ch), .out_mon(out_ch),
        .i_psel, .i_penable, .i_pwrite, .i_paddr, .i_pwdata, .o_pready,
        .fail_count, .points_pending
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 25)
                stall_left <= pick_gap() + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_ch.rx_byte <= b;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_packet();
        for (int i = 0; i < 4; i++) send_byte(sync_now[8*i +: 8]);
        for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(payload[i]);
    endtask

    task automatic fill_payload(input int speed, input int start_a, input int end_a);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            payload[i] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < POINTS_PER_PACKET; i++) begin
            if ($urandom_range(0, 5) == 0) payload[PBASE + 3*i + 2] = 8'd0;
        end
        {payload[1], payload[0]} = speed[15:0];
        {payload[3], payload[2]} = start_a[15:0];
        {payload[EPOS+1], payload[EPOS]} = end_a[15:0];
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= addr;
        i_pwdata <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        int waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (points_pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] sync_val, input int offset);
        settle();
        apb_write(ADDR_SYNC, sync_val);
        apb_write(ADDR_OFFSET, 32'(offset));
        sync_now = sync_val;
    endtask

    task automatic random_packets(input int count);
        int step;
        for (int n = 0; n < count; n++) begin
            no_idle = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    send_byte(sync_now[7:0]);
                    send_byte(sync_now[15:8]);
                    send_byte(~sync_now[23:16]);
                end
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0) start_raw = $urandom_range(0, 65535);
            else start_raw = 40960 + (start_raw - 40960 + $urandom_range(0, 3000)) % 23040;
            step = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                             : start_raw + $urandom_range(1, 1200);
            fill_payload($urandom_range(0, 65535), start_raw, step);
            send_packet();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        i_paddr <= '0;
        i_pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.rx_byte <= '0;
        no_idle = 1'b0;
        sync_now = 32'd134458709;
        start_raw = 40960;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fill_payload(65535, 40960, 40960 + 23039);
        send_packet();
        fill_payload(1000, 0, 40000);
        send_packet();

        configure(32'hFFFF_FFFF, -23040);
        random_packets(1);
        configure(32'h0000_0000, 23040);
        random_packets(1);

        settle();
        if (fail_count == 0 && points_pending == 0) begin
            $display("PASS lidar_packet_to_scan_bins");
        end else begin
            $display("FAIL lidar_packet_to_scan_bins");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL lidar_packet_to_scan_bins");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/lpsb_pkg.sv
design/lpsb_if.sv
design/lpsb_ram.sv
design/lpsb_point.sv
design/lidar_packet_to_scan_bins.sv
sim/lpsb_point_checker.sv
sim/tb_top.sv
